FILE: rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes for the compacting block allocator: status codes,
// opcodes, configuration register indexes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  // fixed field widths of the command and result ports
  localparam int REQ_W     = 32;
  localparam int ID_W      = 5;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM = 8'd1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NO_ROOM    = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_PROTECTED  = 3'd3,
    STAT_EMPTY      = 3'd4,
    STAT_NOT_FOUND  = 3'd5,
    STAT_BAD_CONFIG = 3'd6
  } status_t;

  // control broadcast to the row of table cells
  typedef struct packed {
    logic alloc;  // write the new size at the append position
    logic shift;  // cells at or above the freed slot take their neighbor
  } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/compacting_block_allocator.sv
// ----------------------------------------------------------------------------
// compacting_block_allocator
// Keeps an ordered table of allocated block sizes behind a reserved system
// block and a running free amount; allocates by appending, frees by removing
// a block and compacting the table down.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a clock edge with start high and busy
//   low. opcode selects allocate or free; request_size and block_id carry the
//   operands. Each command gives one result beat on status, result_id,
//   free_remaining and blocks_in_use, marked by done for one cycle; the
//   receiver cannot stall it.
//   Allocate, and every command that ends in an error, answers in the cycle
//   after acceptance and a new command may follow in the next cycle.
//   A successful free first picks the freed slot's size from the cell row and
//   shifts the row down, then in S_FREE adds it back into the free amount
//   (saturating). busy is high while in S_FREE.
//   Configuration: cfg_valid/cfg_ready write channel, index 0 total_size,
//   index 1 system_size; other indexes are dropped. A write to either register
//   empties the table and reloads the free amount. cfg_ready is low while
//   busy and while start is high, so a command always wins the cycle.
//   Reset: total_size 65536, system_size 0, table empty, free = total_size.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode,
  input  wire logic [cba_pkg::REQ_W-1:0]       request_size,
  input  wire logic [cba_pkg::ID_W-1:0]        block_id,
  // result channel
  output logic                                 done,
  output logic [cba_pkg::STAT_W-1:0]           status,
  output logic [cba_pkg::ID_W-1:0]             result_id,
  output logic [cba_pkg::REQ_W-1:0]            free_remaining,
  output logic [cba_pkg::ID_W-1:0]             blocks_in_use,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cba_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CMPW = (CW > cba_pkg::ID_W) ? CW : cba_pkg::ID_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FREE = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [SIZE_BITS-1:0]   total_size, system_size;
  logic [SIZE_BITS-1:0]   free_amount, free_next;
  logic [CW-1:0]          block_count, count_next;
  logic [SIZE_BITS-1:0]   sz_q;
  logic [cba_pkg::ID_W-1:0] rid_q;

  logic [SIZE_BITS-1:0]   req_ext, cfg_val;
  logic [SIZE_BITS-1:0]   new_total, new_system, reinit_free;
  logic                   bad_cfg, cfg_we, cfg_hit, full;
  logic [CMPW-1:0]        cnt_c, id_c, pos_c, inc_c;
  logic [IW-1:0]          pos, wpos;
  logic [SIZE_BITS:0]     sum;
  logic [SIZE_BITS-1:0]   free_sat;
  cba_pkg::status_t       st_code, res_status;
  logic                   do_alloc, do_free, res_load;
  logic [cba_pkg::ID_W-1:0] res_id;
  cba_pkg::cell_op_t      op;

  logic [SIZE_BITS-1:0]   cell_val [MAX_BLOCKS];
  logic [SIZE_BITS-1:0]   cell_sel [MAX_BLOCKS];
  logic [SIZE_BITS-1:0]   sel_size;

  // handshakes
  assign busy      = (state == S_FREE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == cba_pkg::CFG_TOTAL) ||
                     (cfg_index == cba_pkg::CFG_SYSTEM);

  // operand widths
  assign req_ext = SIZE_BITS'(64'(request_size));
  assign cfg_val = SIZE_BITS'(64'(cfg_data));
  assign cnt_c   = CMPW'(block_count);
  assign id_c    = CMPW'(block_id);
  assign pos_c   = id_c - CMPW'(1);
  assign inc_c   = cnt_c + CMPW'(1);
  assign pos     = pos_c[IW-1:0];
  assign wpos    = block_count[IW-1:0];
  assign full    = (block_count == CW'(MAX_BLOCKS));
  assign bad_cfg = (system_size > total_size);

  // free amount after a configuration write
  assign new_total   = (cfg_index == cba_pkg::CFG_TOTAL)  ? cfg_val : total_size;
  assign new_system  = (cfg_index == cba_pkg::CFG_SYSTEM) ? cfg_val : system_size;
  assign reinit_free = (new_system > new_total) ? '0 : (new_total - new_system);

  // saturating return of the freed size
  assign sum      = {1'b0, free_amount} + {1'b0, sz_q};
  assign free_sat = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];

  // command checks, in priority order
  always_comb begin
    st_code  = cba_pkg::STAT_OK;
    do_alloc = 1'b0;
    do_free  = 1'b0;
    priority if (bad_cfg) begin
      st_code = cba_pkg::STAT_BAD_CONFIG;
    end else if (opcode == cba_pkg::OP_ALLOC) begin
      priority if (req_ext > free_amount) begin
        st_code = cba_pkg::STAT_NO_ROOM;
      end else if (full) begin
        st_code = cba_pkg::STAT_FULL;
      end else begin
        do_alloc = 1'b1;
      end
    end else begin
      priority if (block_id == '0) begin
        st_code = cba_pkg::STAT_PROTECTED;
      end else if (block_count == '0) begin
        st_code = cba_pkg::STAT_EMPTY;
      end else if (id_c > cnt_c) begin
        st_code = cba_pkg::STAT_NOT_FOUND;
      end else begin
        do_free = 1'b1;
      end
    end
  end

  // sequencer and next state
  always_comb begin
    state_next = state;
    free_next  = free_amount;
    count_next = block_count;
    res_load   = 1'b0;
    res_status = st_code;
    res_id     = '0;
    op         = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          // only a known register reloads the allocator
          if (cfg_hit) begin
            count_next = '0;
            free_next  = reinit_free;
          end
        end else if (start) begin
          res_load = 1'b1;
          if (do_alloc) begin
            op.alloc   = 1'b1;
            count_next = block_count + CW'(1);
            free_next  = free_amount - req_ext;
            res_id     = inc_c[cba_pkg::ID_W-1:0];
          end else if (do_free) begin
            op.shift   = 1'b1;
            count_next = block_count - CW'(1);
            res_load   = 1'b0;
            state_next = S_FREE;
          end
        end
      end
      S_FREE: begin
        free_next  = free_sat;
        res_load   = 1'b1;
        res_status = cba_pkg::STAT_OK;
        res_id     = rid_q;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // row of table cells
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic [SIZE_BITS-1:0] nbr;
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign nbr = cell_val[i];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    cba_cell #(
      .IDX       (i),
      .IW        (IW),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk  (clk),
      .op   (op),
      .wpos (wpos),
      .pos  (pos),
      .din  (req_ext),
      .nbr  (nbr),
      .val  (cell_val[i]),
      .sel  (cell_sel[i])
    );
  end

  // or-combine of the freed slot's size
  always_comb begin
    sel_size = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      sel_size = sel_size | cell_sel[i];
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      total_size  <= SIZE_BITS'(64'd65536);
      system_size <= '0;
      free_amount <= SIZE_BITS'(64'd65536);
      block_count <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      free_amount <= free_next;
      block_count <= count_next;
      done        <= res_load;
      if (cfg_we) begin
        total_size  <= new_total;
        system_size <= new_system;
      end
    end
  end

  // result beat and free step payload
  always_ff @(posedge clk) begin
    if (op.shift) begin
      sz_q  <= sel_size;
      rid_q <= block_id;
    end
    if (res_load) begin
      status         <= res_status;
      result_id      <= res_id;
      free_remaining <= cba_pkg::REQ_W'(64'(free_next));
      blocks_in_use  <= cba_pkg::ID_W'(CMPW'(count_next));
    end
  end

  // the free step always finishes in the following cycle
  a_free_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("free step did not complete");

  // the table never holds more blocks than it has cells
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    block_count <= CW'(MAX_BLOCKS))
    else $error("block count past table size");

  // an inconsistent configuration leaves nothing free
  a_bad_cfg: assert property (@(posedge clk) disable iff (rst)
    (system_size > total_size) |-> (free_amount == '0))
    else $error("free amount nonzero under bad config");

  // error results carry no id
  a_err_id: assert property (@(posedge clk) disable iff (rst)
    (done && status != cba_pkg::STAT_OK) |-> (result_id == '0))
    else $error("error result with nonzero id");

endmodule

`default_nettype wire

FILE: rtl/cba_cell.sv
// ----------------------------------------------------------------------------
// cba_cell
// One slot of the size table. Loads a new size on append, takes the size of
// its upper neighbor when it or a lower slot is freed, and offers its size when it
// is the slot being freed.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_cell #(
  parameter int IDX       = 0,
  parameter int IW        = 4,
  parameter int SIZE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire cba_pkg::cell_op_t    op,
  input  wire logic [IW-1:0]        wpos,
  input  wire logic [IW-1:0]        pos,
  input  wire logic [SIZE_BITS-1:0] din,
  input  wire logic [SIZE_BITS-1:0] nbr,
  output logic      [SIZE_BITS-1:0] val,
  output logic      [SIZE_BITS-1:0] sel
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic hit;
  logic load;
  logic take;

  // slot decode
  assign hit  = (pos == MY_IDX);
  assign load = op.alloc && (wpos == MY_IDX);
  assign take = op.shift && (MY_IDX >= pos);

  // size of the freed slot, zero elsewhere, for the or-combine in the top
  assign sel = hit ? val : '0;

  // slot storage
  always_ff @(posedge clk) begin
    if (load) begin
      val <= din;
    end else if (take) begin
      val <= nbr;
    end
  end

endmodule

`default_nettype wire
